[hw/rtl/nsfe_pkg.sv]
// nsfe_pkg.sv: types, character codes and lookup functions for the NMEA
// sentence field extractor. No dependencies.
`default_nettype none

package nsfe_pkg;

    // ASCII characters that steer the parser
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam int unsigned HDR_LEN = 5;

    // item_kind codes
    localparam logic ITEM_FIELD = 1'b0;
    localparam logic ITEM_END   = 1'b1;

    // end_reason codes
    localparam logic END_DELIM = 1'b0;
    localparam logic END_LIMIT = 1'b1;

    // sentence_type codes
    localparam logic [1:0] TYPE_NONE = 2'd0;
    localparam logic [1:0] TYPE_RMC  = 2'd1;
    localparam logic [1:0] TYPE_GGA  = 2'd2;
    localparam logic [1:0] TYPE_VTG  = 2'd3;

    // field codes
    localparam logic [3:0] FLD_TIME   = 4'd0;
    localparam logic [3:0] FLD_STATUS = 4'd1;
    localparam logic [3:0] FLD_LAT    = 4'd2;
    localparam logic [3:0] FLD_LON    = 4'd3;
    localparam logic [3:0] FLD_DATE   = 4'd4;
    localparam logic [3:0] FLD_FIX    = 4'd5;
    localparam logic [3:0] FLD_SATS   = 4'd6;
    localparam logic [3:0] FLD_ALT    = 4'd7;
    localparam logic [3:0] FLD_GEOID  = 4'd8;
    localparam logic [3:0] FLD_SPEED  = 4'd9;

    // configuration register indexes
    localparam logic CFG_MAX_LENGTH = 1'b0;
    localparam logic CFG_FIELD_MASK = 1'b1;

    localparam logic [6:0] MAX_LENGTH_RESET = 7'd73;
    localparam logic [9:0] FIELD_MASK_RESET = 10'h3FF;

    typedef struct packed {
        logic [6:0] max_length;
        logic [9:0] field_enable_mask;
    } cfg_t;

    typedef struct packed {
        logic        item_kind;
        logic [1:0]  sentence_type;
        logic [3:0]  field_code;
        logic [7:0]  field_char;
        logic [6:0]  position_in_field;
        logic [6:0]  sentence_length;
        logic        end_reason;
        logic [15:0] sentence_count;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] code;
        logic [2:0] cap;   // 0: no cap
    } field_sel_t;

    // header text: candidate 0 GPRMC, 1 GPGGA, 2 GPVTG
    function automatic logic [7:0] hdr_char(input logic [1:0] cand, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (pos)
            3'd0: c = 8'h47;                    // G
            3'd1: c = 8'h50;                    // P
            3'd2:
            begin
                case (cand)
                    2'd0:    c = 8'h52;         // R
                    2'd1:    c = 8'h47;         // G
                    default: c = 8'h56;         // V
                endcase
            end
            3'd3:
            begin
                case (cand)
                    2'd0:    c = 8'h4D;         // M
                    2'd1:    c = 8'h47;         // G
                    default: c = 8'h54;         // T
                endcase
            end
            3'd4:
            begin
                case (cand)
                    2'd0:    c = 8'h43;         // C
                    2'd1:    c = 8'h41;         // A
                    default: c = 8'h47;         // G
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // field selected by sentence type and comma count
    function automatic field_sel_t field_for(input logic [1:0] stype, input logic [4:0] comma);
        field_sel_t s;
        s = '{hit: 1'b0, code: FLD_TIME, cap: 3'd0};
        case (stype)
            TYPE_RMC:
            begin
                case (comma)
                    5'd1:    s = '{hit: 1'b1, code: FLD_TIME,   cap: 3'd6};
                    5'd2:    s = '{hit: 1'b1, code: FLD_STATUS, cap: 3'd1};
                    5'd3:    s = '{hit: 1'b1, code: FLD_LAT,    cap: 3'd0};
                    5'd5:    s = '{hit: 1'b1, code: FLD_LON,    cap: 3'd0};
                    5'd9:    s = '{hit: 1'b1, code: FLD_DATE,   cap: 3'd6};
                    default: s.hit = 1'b0;
                endcase
            end
            TYPE_GGA:
            begin
                case (comma)
                    5'd6:    s = '{hit: 1'b1, code: FLD_FIX,   cap: 3'd0};
                    5'd7:    s = '{hit: 1'b1, code: FLD_SATS,  cap: 3'd0};
                    5'd9:    s = '{hit: 1'b1, code: FLD_ALT,   cap: 3'd0};
                    5'd11:   s = '{hit: 1'b1, code: FLD_GEOID, cap: 3'd0};
                    default: s.hit = 1'b0;
                endcase
            end
            TYPE_VTG:
            begin
                if (comma == 5'd7)
                begin
                    s = '{hit: 1'b1, code: FLD_SPEED, cap: 3'd0};
                end
            end
            default: s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/nsfe_parser.sv]
// nsfe_parser.sv: per-character sentence state and result decode.
// Depends on nsfe_pkg.
`default_nettype none

module nsfe_parser
    import nsfe_pkg::*;
#(
    parameter int MAX_SENTENCE = 128
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output logic            res_valid,
    output result_t         res
);

    localparam int LIMIT_CAP = MAX_SENTENCE - 1;

    logic        in_sentence_reg,  in_sentence_next;
    logic [6:0]  char_count_reg,   char_count_next;
    logic [2:0]  hdr_pos_reg,      hdr_pos_next;
    logic [2:0]  hdr_cand_reg,     hdr_cand_next;
    logic [1:0]  type_reg,         type_next;
    logic [4:0]  comma_reg,        comma_next;
    logic [6:0]  field_pos_reg,    field_pos_next;
    logic [15:0] ended_reg,        ended_next;

    logic       [6:0] limit;
    logic             is_delim;
    field_sel_t       sel;
    logic       [2:0] cand_upd;

    always_comb
    begin
        if (LIMIT_CAP < 127 && int'(cfg.max_length) > LIMIT_CAP)
        begin
            limit = 7'(LIMIT_CAP);
        end
        else
        begin
            limit = cfg.max_length;
        end
    end

    assign is_delim = (rx_byte == CH_CR) || (rx_byte == CH_LF) || (rx_byte == CH_STAR);
    assign sel      = field_for(type_reg, comma_reg);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cand_upd[k] = hdr_cand_reg[k] && (hdr_char(2'(k), hdr_pos_reg) == rx_byte);
        end
    end

    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        char_count_next  = char_count_reg;
        hdr_pos_next     = hdr_pos_reg;
        hdr_cand_next    = hdr_cand_reg;
        type_next        = type_reg;
        comma_next       = comma_reg;
        field_pos_next   = field_pos_reg;
        ended_next       = ended_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (rx_byte == CH_DOLLAR)
        begin
            // open or restart
            in_sentence_next = 1'b1;
            char_count_next  = 7'd1;
            hdr_pos_next     = 3'd0;
            hdr_cand_next    = 3'b111;
            type_next        = TYPE_NONE;
            comma_next       = 5'd0;
            field_pos_next   = 7'd0;
        end
        else if (in_sentence_reg)
        begin
            if (is_delim || char_count_reg >= limit)
            begin
                ended_next            = ended_reg + 16'd1;
                res_valid             = 1'b1;
                res.item_kind         = ITEM_END;
                res.sentence_type     = type_reg;
                res.sentence_length   = char_count_reg;
                res.end_reason        = is_delim ? END_DELIM : END_LIMIT;
                res.sentence_count    = ended_next;
                in_sentence_next      = 1'b0;
                char_count_next       = 7'd0;
                hdr_pos_next          = 3'd0;
                hdr_cand_next         = 3'b111;
                type_next             = TYPE_NONE;
                comma_next            = 5'd0;
                field_pos_next        = 7'd0;
            end
            else
            begin
                char_count_next = char_count_reg + 7'd1;
                if (hdr_pos_reg < 3'(HDR_LEN))
                begin
                    hdr_cand_next = cand_upd;
                    hdr_pos_next  = hdr_pos_reg + 3'd1;
                    if (hdr_pos_next == 3'(HDR_LEN))
                    begin
                        // later candidate wins, as in a forward scan
                        if (cand_upd[2])
                        begin
                            type_next = TYPE_VTG;
                        end
                        else if (cand_upd[1])
                        begin
                            type_next = TYPE_GGA;
                        end
                        else if (cand_upd[0])
                        begin
                            type_next = TYPE_RMC;
                        end
                        else
                        begin
                            type_next = TYPE_NONE;
                        end
                    end
                end
                else if (rx_byte == CH_COMMA)
                begin
                    if (comma_reg != 5'd31)
                    begin
                        comma_next = comma_reg + 5'd1;
                    end
                    field_pos_next = 7'd0;
                end
                else
                begin
                    if (field_pos_reg != 7'd127)
                    begin
                        field_pos_next = field_pos_reg + 7'd1;
                    end
                    if (sel.hit && cfg.field_enable_mask[sel.code] &&
                        (sel.cap == 3'd0 || field_pos_reg < 7'(sel.cap)))
                    begin
                        res_valid             = 1'b1;
                        res.item_kind         = ITEM_FIELD;
                        res.sentence_type     = type_reg;
                        res.field_code        = sel.code;
                        res.field_char        = rx_byte;
                        res.position_in_field = field_pos_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg <= 1'b0;
            char_count_reg  <= 7'd0;
            hdr_pos_reg     <= 3'd0;
            hdr_cand_reg    <= 3'b111;
            type_reg        <= TYPE_NONE;
            comma_reg       <= 5'd0;
            field_pos_reg   <= 7'd0;
            ended_reg       <= 16'd0;
        end
        else if (step)
        begin
            in_sentence_reg <= in_sentence_next;
            char_count_reg  <= char_count_next;
            hdr_pos_reg     <= hdr_pos_next;
            hdr_cand_reg    <= hdr_cand_next;
            type_reg        <= type_next;
            comma_reg       <= comma_next;
            field_pos_reg   <= field_pos_next;
            ended_reg       <= ended_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_sentence_reg |-> (char_count_reg == 7'd0 && hdr_pos_reg == 3'd0 &&
                              comma_reg == 5'd0))
        else $error("parser state not cleared outside a sentence");
    a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg <= 3'(HDR_LEN))
        else $error("header position past header");
    a_type_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (type_reg != TYPE_NONE) |-> (hdr_pos_reg == 3'(HDR_LEN)))
        else $error("sentence type set before header complete");
`endif

endmodule

`default_nettype wire

[hw/rtl/nmea_sentence_field_extractor_core.sv]
// nmea_sentence_field_extractor_core.sv: top level, input and result registers,
// configuration registers. Depends on nsfe_pkg and nsfe_parser.
`default_nettype none

//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_stall  | rx_byte
//  out     | out_valid/out_stall| item_kind, sentence_type, field_code,
//          |                    | field_char, position_in_field,
//          |                    | sentence_length, end_reason, sentence_count
//  cfg     | cfg_we             | cfg_addr, cfg_wdata
//
//  One request per cycle sustained while the result register is free; a
//  request's result (if any) goes from the input register through the parse
//  logic into the result register, which loads it once it is free.
//  Reset clears the sentence state, the sentence counter and the config
//  registers (max_length 73, all fields enabled).
//  A stalled result holds the result register; in_stall then rises only once
//  the input register also holds a request.

module nmea_sentence_field_extractor_core
    import nsfe_pkg::*;
#(
    parameter int MAX_SENTENCE = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             item_kind,
    output logic [1:0]       sentence_type,
    output logic [3:0]       field_code,
    output logic [7:0]       field_char,
    output logic [6:0]       position_in_field,
    output logic [6:0]       sentence_length,
    output logic             end_reason,
    output logic [15:0]      sentence_count,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [9:0]  cfg_wdata
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;

    logic       out_free;   // result register can load this cycle
    logic       advance;    // held request moves through the parser
    logic       res_valid;
    result_t    res;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_length        <= MAX_LENGTH_RESET;
            cfg_reg.field_enable_mask <= FIELD_MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MAX_LENGTH: cfg_reg.max_length        <= cfg_wdata[6:0];
                CFG_FIELD_MASK: cfg_reg.field_enable_mask <= cfg_wdata;
                default:        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    nsfe_parser #(
        .MAX_SENTENCE (MAX_SENTENCE)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register; requests that give no result leave it empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign item_kind         = out_res_reg.item_kind;
    assign sentence_type     = out_res_reg.sentence_type;
    assign field_code        = out_res_reg.field_code;
    assign field_char        = out_res_reg.field_char;
    assign position_in_field = out_res_reg.position_in_field;
    assign sentence_length   = out_res_reg.sentence_length;
    assign end_reason        = out_res_reg.end_reason;
    assign sentence_count    = out_res_reg.sentence_count;

`ifndef SYNTHESIS
    a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held request lost while result register blocked");
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && item_kind == ITEM_END) |->
            (field_code == 4'd0 && field_char == 8'd0 && position_in_field == 7'd0))
        else $error("end item carries field data");
    a_field_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && item_kind == ITEM_FIELD) |->
            (sentence_length == 7'd0 && end_reason == END_DELIM &&
             sentence_count == 16'd0 && sentence_type != TYPE_NONE))
        else $error("field item carries end data or no type");
`endif

endmodule

`default_nettype wire

[tb/tb_nmea_sentence_field_extractor_core.sv]
// tb_nmea_sentence_field_extractor_core.sv: self-checking testbench for the NMEA sentence
// field extractor core, with a directed table, then random sentences under several settings.
// Depends on nsfe_pkg and nmea_sentence_field_extractor_core.
`timescale 1ns / 1ps

module tb_nmea_sentence_field_extractor_core;
    import nsfe_pkg::*;

    localparam int SENT_MAX  = 128;     // must match the core's MAX_SENTENCE
    localparam int SEG_BYTES = 90;      // random requests per register setting

    // One queued request: the byte, plus an optional typed-in result that
    // replaces the parser model's prediction for that row.
    typedef struct packed {
        logic [7:0] data;
        logic       pinned;
        result_t    want;
    } rx_req_t;

    // ---------------------------------------------------------------
    // DUT ports
    // ---------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        item_kind;
    logic [1:0]  sentence_type;
    logic [3:0]  field_code;
    logic [7:0]  field_char;
    logic [6:0]  position_in_field;
    logic [6:0]  sentence_length;
    logic        end_reason;
    logic [15:0] sentence_count;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [9:0]  cfg_wdata = 10'h000;

    nmea_sentence_field_extractor_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .item_kind        (item_kind),
        .sentence_type    (sentence_type),
        .field_code       (field_code),
        .field_char       (field_char),
        .position_in_field(position_in_field),
        .sentence_length  (sentence_length),
        .end_reason       (end_reason),
        .sentence_count   (sentence_count),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------
    // Parser model state: a private copy of the sentence state and of
    // both configuration registers.
    // ---------------------------------------------------------------
    logic [6:0]  cfg_max_len = MAX_LENGTH_RESET;
    logic [9:0]  cfg_fld_mask = FIELD_MASK_RESET;

    logic        s_open = 1'b0;
    int          s_chars = 0;
    int          s_hdr_pos = 0;
    logic [2:0]  s_hdr_match = 3'b111;
    logic [1:0]  s_type = TYPE_NONE;
    int          s_commas = 0;
    int          s_fpos = 0;
    logic [15:0] s_ended = 16'd0;

    rx_req_t     rx_backlog[$];         // requests waiting to be offered
    result_t     items_due[$];          // predicted results, oldest first

    int          fails = 0;
    int          queued = 0;
    int          accepted = 0;
    int          checked = 0;
    int          ends_seen = 0;

    // idle control, set per phase by the sequencer
    int          tx_pct = 0;
    int          rx_pct = 0;
    int          tx_burst = 0;
    int          rx_burst = 0;

    // Header letter i of candidate k (0 RMC, 1 GGA, 2 VTG)
    function automatic logic [7:0] hdr_letter(input int k, input int i);
        logic [39:0] txt;
        case (k)
            0:       txt = "GPRMC";
            1:       txt = "GPGGA";
            default: txt = "GPVTG";
        endcase
        return txt[39 - 8 * i -: 8];
    endfunction

    task automatic drop_sentence();
        s_open      = 1'b0;
        s_chars     = 0;
        s_hdr_pos   = 0;
        s_hdr_match = 3'b111;
        s_type      = TYPE_NONE;
        s_commas    = 0;
        s_fpos      = 0;
    endtask

    // Advance the parser model by one byte; hit says whether a result comes out.
    task automatic parse_rx_byte(input logic [7:0] b, output logic hit, output result_t r);
        int   code;
        int   cap;
        int   pos;
        int   limit;
        logic delim;
        hit   = 1'b0;
        r     = '0;
        delim = (b == CH_CR) || (b == CH_LF) || (b == CH_STAR);
        limit = (cfg_max_len > SENT_MAX - 1) ? SENT_MAX - 1 : cfg_max_len;

        // '$' always (re)opens, even mid-sentence
        if (b == CH_DOLLAR)
        begin
            drop_sentence();
            s_open  = 1'b1;
            s_chars = 1;
            return;
        end
        if (!s_open)
        begin
            return;
        end

        // delimiter, or the byte that arrives once the limit is reached
        if (delim || s_chars >= limit)
        begin
            s_ended           = s_ended + 16'd1;
            hit               = 1'b1;
            r.item_kind       = ITEM_END;
            r.sentence_type   = s_type;
            r.sentence_length = s_chars[6:0];
            r.end_reason      = delim ? END_DELIM : END_LIMIT;
            r.sentence_count  = s_ended;
            drop_sentence();
            return;
        end

        s_chars++;

        // header: knock out candidates letter by letter
        if (s_hdr_pos < HDR_LEN)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (hdr_letter(k, s_hdr_pos) != b)
                begin
                    s_hdr_match[k] = 1'b0;
                end
            end
            s_hdr_pos++;
            if (s_hdr_pos == HDR_LEN)
            begin
                s_type = TYPE_NONE;
                for (int k = 0; k < 3; k++)
                begin
                    if (s_hdr_match[k])
                    begin
                        s_type = 2'(k + 1);
                    end
                end
            end
            return;
        end

        if (b == CH_COMMA)
        begin
            if (s_commas < 31)
            begin
                s_commas++;
            end
            s_fpos = 0;
            return;
        end

        // which field this comma count selects, and its length cap
        code = -1;
        cap  = 0;
        case (s_type)
            TYPE_RMC:
            begin
                case (s_commas)
                    1:       begin code = FLD_TIME;   cap = 6; end
                    2:       begin code = FLD_STATUS; cap = 1; end
                    3:       code = FLD_LAT;
                    5:       code = FLD_LON;
                    9:       begin code = FLD_DATE;   cap = 6; end
                    default: code = -1;
                endcase
            end
            TYPE_GGA:
            begin
                case (s_commas)
                    6:       code = FLD_FIX;
                    7:       code = FLD_SATS;
                    9:       code = FLD_ALT;
                    11:      code = FLD_GEOID;
                    default: code = -1;
                endcase
            end
            TYPE_VTG:
            begin
                if (s_commas == 7)
                begin
                    code = FLD_SPEED;
                end
            end
            default: code = -1;
        endcase

        pos = s_fpos;
        if (s_fpos < 127)
        begin
            s_fpos++;
        end
        if (code < 0 || !cfg_fld_mask[code] || (cap != 0 && pos >= cap))
        begin
            return;
        end
        hit                 = 1'b1;
        r.item_kind         = ITEM_FIELD;
        r.sentence_type     = s_type;
        r.field_code        = code[3:0];
        r.field_char        = b;
        r.position_in_field = pos[6:0];
    endtask

    task automatic check_result(input result_t want, input result_t got);
        if (got.item_kind !== want.item_kind)
        begin
            $error("item_kind: expected %0d, got %0d", want.item_kind, got.item_kind);
            fails++;
        end
        if (got.sentence_type !== want.sentence_type)
        begin
            $error("sentence_type: expected %0d, got %0d",
                   want.sentence_type, got.sentence_type);
            fails++;
        end
        if (got.field_code !== want.field_code)
        begin
            $error("field_code: expected %0d, got %0d", want.field_code, got.field_code);
            fails++;
        end
        if (got.field_char !== want.field_char)
        begin
            $error("field_char: expected 0x%02h, got 0x%02h", want.field_char, got.field_char);
            fails++;
        end
        if (got.position_in_field !== want.position_in_field)
        begin
            $error("position_in_field: expected %0d, got %0d",
                   want.position_in_field, got.position_in_field);
            fails++;
        end
        if (got.sentence_length !== want.sentence_length)
        begin
            $error("sentence_length: expected %0d, got %0d",
                   want.sentence_length, got.sentence_length);
            fails++;
        end
        if (got.end_reason !== want.end_reason)
        begin
            $error("end_reason: expected %0d, got %0d", want.end_reason, got.end_reason);
            fails++;
        end
        if (got.sentence_count !== want.sentence_count)
        begin
            $error("sentence_count: expected %0d, got %0d",
                   want.sentence_count, got.sentence_count);
            fails++;
        end
    endtask

    // ---------------------------------------------------------------
    // Both channels in one clocked process. The result side is handled
    // before the request side so a request accepted on this edge can
    // never be mistaken for the one whose result is arriving.
    // Outputs are read in the active region, i.e. their pre-edge values.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t pred;
        logic    hit;
        rx_req_t cur;
        logic    tx_pause;
        logic    rx_pause;
        if (rst_n)
        begin
            // result channel
            if (out_valid && !out_stall)
            begin
                got = {item_kind, sentence_type, field_code, field_char, position_in_field,
                       sentence_length, end_reason, sentence_count};
                if (items_due.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d char 0x%02h",
                           item_kind, field_char);
                    fails++;
                end
                else
                begin
                    check_result(items_due.pop_front(), got);
                    checked++;
                    if (got.item_kind == ITEM_END)
                    begin
                        ends_seen++;
                    end
                end
            end

            // random stall, with occasional stall-free bursts
            if (rx_burst > 0)
            begin
                rx_burst--;
                rx_pause = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                begin
                    rx_burst = $urandom_range(10, 40);
                end
                rx_pause = ($urandom_range(0, 99) < rx_pct);
            end
            out_stall <= rx_pause;

            // request channel: an accepted request steps the parser model
            if (in_valid && !in_stall)
            begin
                cur = rx_backlog.pop_front();
                accepted++;
                parse_rx_byte(cur.data, hit, pred);
                if (cur.pinned)
                begin
                    items_due.push_back(cur.want);
                end
                else if (hit)
                begin
                    items_due.push_back(pred);
                end
            end

            if (tx_burst > 0)
            begin
                tx_burst--;
                tx_pause = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                begin
                    tx_burst = $urandom_range(10, 40);
                end
                tx_pause = ($urandom_range(0, 99) < tx_pct);
            end

            // a stalled request holds; otherwise offer the next or go idle
            if (!(in_valid && in_stall))
            begin
                if (rx_backlog.size() != 0 && !tx_pause)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_backlog[0].data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic rx_req_t row(input logic [7:0] b);
        return '{data: b, pinned: 1'b0, want: '0};
    endfunction

    // row whose end item is typed in by hand (always a delimiter end)
    function automatic rx_req_t row_end(input logic [7:0] b, input logic [1:0] t,
                                        input logic [6:0] len, input logic [15:0] n);
        result_t r;
        r                 = '0;
        r.item_kind       = ITEM_END;
        r.sentence_type   = t;
        r.sentence_length = len;
        r.end_reason      = END_DELIM;
        r.sentence_count  = n;
        return '{data: b, pinned: 1'b1, want: r};
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        rx_backlog.push_back(row(b));
        queued++;
    endtask

    // printable field content, never a character that steers the parser
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(32, 126));
        end
        while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
        return c;
    endfunction

    // Mostly well-formed sentences with random content; the rest have broken
    // headers, truncated headers, stray bytes, comma storms or no terminator.
    task automatic queue_sentence();
        logic [39:0] hdr;
        logic [7:0]  c;
        int          shape;
        int          hlen;
        int          nf;
        int          flen;
        int          tail;
        int          i;
        int          j;
        shape = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0:       hdr = "GPRMC";
            1:       hdr = "GPGGA";
            default: hdr = "GPVTG";
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            queue_byte(8'($urandom_range(0, 255)));     // noise between sentences
        end
        queue_byte(CH_DOLLAR);

        hlen = (shape < 94) ? 5 : $urandom_range(0, 4);
        for (i = 0; i < hlen; i++)
        begin
            c = hdr[39 - 8 * i -: 8];
            if (shape >= 75 && $urandom_range(0, 3) == 0)
            begin
                c = 8'($urandom_range(0, 255));
            end
            queue_byte(c);
        end
        if (hlen < 5)
        begin
            queue_byte(CH_CR);      // ends inside the header
            return;
        end

        // comma storm drives the comma counter into saturation
        nf = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 13);
        for (i = 0; i < nf; i++)
        begin
            queue_byte(CH_COMMA);
            if (nf > 20)
            begin
                flen = $urandom_range(0, 1);
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                flen = $urandom_range(20, 90);
            end
            else
            begin
                flen = $urandom_range(0, 8);
            end
            for (j = 0; j < flen; j++)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    c = 8'($urandom_range(0, 255));
                end
                else
                begin
                    c = body_char();
                end
                queue_byte(c);
            end
        end

        tail = $urandom_range(0, 99);
        if (tail < 40)
        begin
            queue_byte(CH_CR);
            queue_byte(CH_LF);      // LF lands outside the sentence
        end
        else if (tail < 60)
        begin
            queue_byte(CH_STAR);
            queue_byte("4");
            queue_byte("7");
            queue_byte(CH_CR);
            queue_byte(CH_LF);
        end
        else if (tail < 75)
        begin
            queue_byte(CH_LF);
        end
        else if (tail >= 90)
        begin
            repeat ($urandom_range(1, 4))
            begin
                queue_byte(8'($urandom_range(0, 255)));
            end
        end
        // 75..89: no terminator, runs into the next '$' or the length limit
    endtask

    // Wait until every request is taken and every result is back, then wait on
    // for requests that cause no result and are still in flight.
    task automatic settle();
        int guard;
        guard = 0;
        while (rx_backlog.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (items_due.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    // Both registers, back to back; write enable stays high across the pair.
    task automatic load_config(input logic [6:0] max_len, input logic [9:0] mask);
        logic [2:0] junk;
        junk = 3'($urandom);       // upper bits of the max_length write are ignored
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_MAX_LENGTH;
        cfg_wdata <= {junk, max_len};
        @(posedge clk);
        cfg_addr  <= CFG_FIELD_MASK;
        cfg_wdata <= mask;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_max_len  = max_len;
        cfg_fld_mask = mask;
    endtask

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    rx_req_t directed_rows [22];

    initial
    begin
        logic [6:0] ml;
        logic [9:0] mk;
        int         start;

        // Directed table, run with reset register values.
        directed_rows = '{
            row("A"),                                   // outside any sentence
            row(CH_DOLLAR),
            row(CH_DOLLAR),                             // repeated '$' restarts
            row("G"),
            row_end(CH_CR, TYPE_NONE, 7'd2, 16'd1),     // delimiter inside header
            row(CH_DOLLAR),
            row("G"), row("P"), row("R"), row("M"), row("C"),
            row(CH_COMMA),
            row(8'hFF),                                 // time, position 0
            row("0"),                                   // time, position 1
            row(CH_COMMA),
            row("A"),                                   // status
            row("V"),                                   // status past its cap
            row_end(CH_STAR, TYPE_RMC, 7'd12, 16'd2),
            row(CH_DOLLAR),
            row(CH_COMMA),                              // bad header character
            row_end(CH_LF, TYPE_NONE, 7'd2, 16'd3),
            row(8'h00)                                  // outside again
        };

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        tx_pct = 34;
        rx_pct = 77;
        foreach (directed_rows[i])
        begin
            rx_backlog.push_back(directed_rows[i]);
            queued++;
        end

        // Three idling phases, three register settings each.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:       begin tx_pct = 34; rx_pct = 77; end
                1:       begin tx_pct = 77; rx_pct = 34; end
                default: begin tx_pct = 0;  rx_pct = 0;  end
            endcase
            for (int seg = 0; seg < 3; seg++)
            begin
                settle();
                case (ph * 3 + seg)
                    0:       begin ml = 7'd127; mk = 10'h3FF; end
                    1:       begin ml = 7'd8;   mk = 10'h000; end
                    2:       begin ml = 7'd73;  mk = 10'($urandom); end
                    3:       begin ml = 7'd20;  mk = 10'h3FF; end
                    4:       begin ml = 7'd127; mk = 10'($urandom); end
                    5:       begin ml = 7'd8;   mk = 10'h3FF; end
                    6:       begin ml = 7'($urandom_range(8, 127)); mk = 10'($urandom); end
                    7:       begin ml = 7'd45;  mk = 10'h3FF ^ (10'd1 << $urandom_range(0, 9)); end
                    default: begin ml = 7'd100; mk = 10'($urandom); end
                endcase
                load_config(ml, mk);
                start = queued;
                while (queued - start < SEG_BYTES)
                begin
                    queue_sentence();
                end
            end
        end

        settle();
        if (items_due.size() != 0)
        begin
            $error("%0d expected results never arrived", items_due.size());
            fails++;
        end

        $display("covered %0d requests over 10 register settings and 3 idling phases",
                 accepted);
        $display("checked %0d results, %0d of them sentence ends", checked, ends_seen);
        if (fails == 0)
        begin
            $display("nmea_sentence_field_extractor_core regression: pass");
        end
        else
        begin
            $display("nmea_sentence_field_extractor_core regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("nmea_sentence_field_extractor_core regression: fail");
        $finish;
    end

endmodule
